>>> hw/rtl/ebtng_pkg.sv
// ----------------------------------------------------------------------------
// ebtng_pkg
// Shared types, widths and register codes for the event batch trigger.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ebtng_pkg;

    // field widths
    localparam int TS_W       = 48;
    localparam int CNT_W      = 32;
    localparam int PERIOD_W   = 32;
    localparam int WIN_W      = 13;
    localparam int RATE_W     = 30;
    localparam int SPAN_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // rate compare: window * 1e6 against rate * span
    localparam int US_PER_S   = 1000000;
    localparam int LHS_W      = WIN_W + 20;
    localparam int PROD_W     = RATE_W + SPAN_W;

    // parameter defaults
    localparam int RING_DEPTH_DEF  = 4096;
    localparam int QUEUE_DEPTH_DEF = 4;

    // register reset values
    localparam logic [PERIOD_W-1:0] PERIOD_RST     = PERIOD_W'(10000);
    localparam logic [CNT_W-1:0]    MIN_EVENTS_RST = CNT_W'(1000);
    localparam logic [WIN_W-1:0]    WINDOW_RST     = WIN_W'(100);
    localparam logic [RATE_W-1:0]   RATE_RST       = '0;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE       = 3'd0,
        CFG_PERIOD     = 3'd1,
        CFG_MIN_EVENTS = 3'd2,
        CFG_WINDOW     = 3'd3,
        CFG_RATE       = 3'd4
    } cfg_reg_t;

    typedef enum logic {
        MODE_TIME  = 1'b0,
        MODE_COUNT = 1'b1
    } acc_mode_t;

    typedef struct packed {
        acc_mode_t           mode;
        logic [PERIOD_W-1:0] period_us;
        logic [CNT_W-1:0]    min_new_events;
        logic [WIN_W-1:0]    noise_window;
        logic [RATE_W-1:0]   noise_rate_per_s;
    } cfg_t;

    // one batch-end record passed from front to back
    typedef struct packed {
        logic            fire;
        logic            form_rate;
        logic [TS_W-1:0] frame_time;
        logic [TS_W-1:0] old_time;
    } rec_t;

endpackage

>>> hw/rtl/event_batch_trigger_noise_gate.sv
// ----------------------------------------------------------------------------
// event_batch_trigger_noise_gate
// A batch-end request passes the read stage, the queue and the back pipeline.
// Throughput: one event per cycle while in_ready is high; the ring takes one
// write per event and one read per batch end, and a 4-entry queue decouples
// intake from the rate gate. Reset: counters, trigger time, ring index and fill
// clear at once; the ring is not cleared and an entry is used only if written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module event_batch_trigger_noise_gate #(
    parameter int RING_DEPTH  = ebtng_pkg::RING_DEPTH_DEF,
    parameter int QUEUE_DEPTH = ebtng_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ebtng_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ebtng_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [ebtng_pkg::TS_W-1:0]       timestamp_us,
    input  logic                             last_in_batch,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             batch_ready,
    output logic                             rate_ok,
    output logic [ebtng_pkg::TS_W-1:0]       frame_time_us
);

    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    ebtng_pkg::cfg_t cfg_reg, cfg_next;
    logic            push;
    logic            pop;
    logic            q_valid;
    logic [QCW-1:0]  q_count;
    ebtng_pkg::rec_t push_data;
    ebtng_pkg::rec_t head;

    // configuration register writes
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (ebtng_pkg::cfg_reg_t'(cfg_index))
                ebtng_pkg::CFG_MODE:
                    cfg_next.mode = ebtng_pkg::acc_mode_t'(cfg_data[0]);
                ebtng_pkg::CFG_PERIOD:
                    cfg_next.period_us = cfg_data[ebtng_pkg::PERIOD_W-1:0];
                ebtng_pkg::CFG_MIN_EVENTS:
                    cfg_next.min_new_events = cfg_data[ebtng_pkg::CNT_W-1:0];
                ebtng_pkg::CFG_WINDOW:
                    cfg_next.noise_window = cfg_data[ebtng_pkg::WIN_W-1:0];
                ebtng_pkg::CFG_RATE:
                    cfg_next.noise_rate_per_s = cfg_data[ebtng_pkg::RATE_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode             <= ebtng_pkg::MODE_COUNT;
            cfg_reg.period_us        <= ebtng_pkg::PERIOD_RST;
            cfg_reg.min_new_events   <= ebtng_pkg::MIN_EVENTS_RST;
            cfg_reg.noise_window     <= ebtng_pkg::WINDOW_RST;
            cfg_reg.noise_rate_per_s <= ebtng_pkg::RATE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // intake and trigger
    ebtng_front #(
        .RING_DEPTH  (RING_DEPTH),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .timestamp_us  (timestamp_us),
        .last_in_batch (last_in_batch),
        .q_count       (q_count),
        .push          (push),
        .push_data     (push_data)
    );

    // decoupling queue
    ebtng_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .not_empty (q_valid),
        .count     (q_count)
    );

    // rate gate and result register
    ebtng_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_valid       (q_valid),
        .head          (head),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .batch_ready   (batch_ready),
        .rate_ok       (rate_ok),
        .frame_time_us (frame_time_us)
    );

endmodule

>>> hw/rtl/ebtng_ram.sv
// ----------------------------------------------------------------------------
// ebtng_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ebtng_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/ebtng_queue.sv
// ----------------------------------------------------------------------------
// ebtng_queue
// Short register queue of batch-end records between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ebtng_queue #(
    parameter int DEPTH = ebtng_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  ebtng_pkg::rec_t            push_data,
    input  logic                       pop,
    output ebtng_pkg::rec_t            head,
    output logic                       not_empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    ebtng_pkg::rec_t slot_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (!push && pop)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // record storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head      = slot_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

`ifndef SYNTH
    // front must hold back once every slot is taken
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == CW'(DEPTH)) |-> (!push || pop))
        else $error("queue push while full");

    // back only pops a record that is there
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("queue pop while empty");

    // fill level stays within the storage
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count out of range");
`endif

endmodule

>>> hw/rtl/ebtng_front.sv
// ----------------------------------------------------------------------------
// ebtng_front
// Intake: ring write, event counting, trigger decision and ring read issue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ebtng_front #(
    parameter int RING_DEPTH  = ebtng_pkg::RING_DEPTH_DEF,
    parameter int QUEUE_DEPTH = ebtng_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  ebtng_pkg::cfg_t                  cfg,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [ebtng_pkg::TS_W-1:0]       timestamp_us,
    input  logic                             last_in_batch,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count,
    output logic                             push,
    output ebtng_pkg::rec_t                  push_data
);

    localparam int TS_W  = ebtng_pkg::TS_W;
    localparam int CNT_W = ebtng_pkg::CNT_W;
    localparam int WIN_W = ebtng_pkg::WIN_W;
    localparam int AW    = $clog2(RING_DEPTH);
    localparam int FW    = $clog2(RING_DEPTH + 1);
    localparam int CMPW  = (FW > WIN_W) ? FW : WIN_W;
    localparam int QCW   = $clog2(QUEUE_DEPTH + 1);

    logic [AW-1:0]    wr_idx_reg, wr_idx_next;
    logic [FW-1:0]    fill_reg, fill_next;
    logic [CNT_W-1:0] events_reg, events_next;
    logic [TS_W-1:0]  last_trig_reg, last_trig_next;
    logic             p1_valid_reg;
    logic             p1_fire_reg;
    logic             p1_form_reg;
    logic [TS_W-1:0]  p1_time_reg;

    logic             accept;
    logic [CNT_W-1:0] events_inc;
    logic             fire;
    logic             form_rate;
    logic [CMPW-1:0]  window_ext;
    logic [FW:0]      pos_diff;
    logic [FW:0]      pos_wrap;
    logic [AW-1:0]    rd_addr;
    logic [TS_W-1:0]  old_time;

    // credit: room for this request and the one in the read stage
    assign in_ready = ({1'b0, q_count} + (QCW + 1)'(p1_valid_reg))
                      < (QCW + 1)'(QUEUE_DEPTH);
    assign accept   = in_valid && in_ready;

    // ring index, fill level and counters after this event
    always_comb
    begin
        wr_idx_next = (wr_idx_reg == AW'(RING_DEPTH - 1)) ? '0 : wr_idx_reg + AW'(1);
        fill_next   = (fill_reg == FW'(RING_DEPTH)) ? fill_reg : fill_reg + FW'(1);
        events_inc  = (events_reg == '1) ? events_reg : events_reg + CNT_W'(1);
    end

    // trigger decision at batch end
    always_comb
    begin
        if (cfg.mode == ebtng_pkg::MODE_TIME)
        begin
            fire = {1'b0, timestamp_us}
                   >= ({1'b0, last_trig_reg} + (TS_W + 1)'(cfg.period_us));
        end
        else
        begin
            fire = events_inc > cfg.min_new_events;
        end
    end

    // rate is only formed when the window is inside the fill; a window of one
    // always has zero span, so it is treated as no rate
    always_comb
    begin
        window_ext = CMPW'(cfg.noise_window);
        form_rate  = (cfg.noise_window > WIN_W'(1)) && (CMPW'(fill_next) > window_ext);
        pos_diff   = (FW + 1)'(wr_idx_next) - {1'b0, window_ext[FW-1:0]};
        pos_wrap   = pos_diff[FW] ? pos_diff + (FW + 1)'(RING_DEPTH) : pos_diff;
        rd_addr    = pos_wrap[AW-1:0];
    end

    // next state of the batch bookkeeping
    always_comb
    begin
        events_next    = events_reg;
        last_trig_next = last_trig_reg;
        if (accept)
        begin
            events_next = events_inc;
            if (last_in_batch && fire)
            begin
                events_next    = '0;
                last_trig_next = timestamp_us;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg    <= '0;
            fill_reg      <= '0;
            events_reg    <= '0;
            last_trig_reg <= '0;
            p1_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                wr_idx_reg <= wr_idx_next;
                fill_reg   <= fill_next;
            end
            events_reg    <= events_next;
            last_trig_reg <= last_trig_next;
            p1_valid_reg  <= accept && last_in_batch;
        end
    end

    // read stage payload, registered alongside the ring read data
    always_ff @(posedge clk)
    begin
        if (accept && last_in_batch)
        begin
            p1_fire_reg <= fire;
            p1_form_reg <= form_rate;
            p1_time_reg <= timestamp_us;
        end
    end

    // timestamp ring
    ebtng_ram #(
        .WIDTH (TS_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (accept),
        .waddr (wr_idx_reg),
        .wdata (timestamp_us),
        .re    (accept && last_in_batch),
        .raddr (rd_addr),
        .rdata (old_time)
    );

    // hand the completed request to the queue
    assign push                 = p1_valid_reg;
    assign push_data.fire       = p1_fire_reg;
    assign push_data.form_rate  = p1_form_reg;
    assign push_data.frame_time = p1_time_reg;
    assign push_data.old_time   = old_time;

endmodule

>>> hw/rtl/ebtng_back.sv
// ----------------------------------------------------------------------------
// ebtng_back
// Rate gate pipeline: span, products, compare and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ebtng_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  ebtng_pkg::cfg_t            cfg,
    input  logic                       q_valid,
    input  ebtng_pkg::rec_t            head,
    output logic                       pop,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       batch_ready,
    output logic                       rate_ok,
    output logic [ebtng_pkg::TS_W-1:0] frame_time_us
);

    localparam int TS_W   = ebtng_pkg::TS_W;
    localparam int SPAN_W = ebtng_pkg::SPAN_W;
    localparam int LHS_W  = ebtng_pkg::LHS_W;
    localparam int PROD_W = ebtng_pkg::PROD_W;

    logic              b1_valid_reg;
    logic              b1_fire_reg;
    logic [TS_W-1:0]   b1_time_reg;
    logic [SPAN_W-1:0] b1_span_reg, span_next;

    logic              b2_valid_reg;
    logic              b2_fire_reg;
    logic [TS_W-1:0]   b2_time_reg;
    logic              b2_zero_reg;
    logic [LHS_W-1:0]  b2_lhs_reg, lhs_next;
    logic [PROD_W-1:0] b2_prod_reg, prod_next;

    logic              out_valid_reg;
    logic              out_fire_reg;
    logic              out_rate_ok_reg, rate_ok_next;
    logic [TS_W-1:0]   out_time_reg;

    logic              out_en;
    logic              b2_en;
    logic              b1_en;
    logic [TS_W-1:0]   span_full;

    // stage enables, each stage moves when the next one has room
    assign out_en = !out_valid_reg || out_ready;
    assign b2_en  = !b2_valid_reg || out_en;
    assign b1_en  = !b1_valid_reg || b2_en;
    assign pop    = q_valid && b1_en;

    // span from the oldest window entry, saturated to 32 bits
    always_comb
    begin
        span_full = head.frame_time - head.old_time;
        if (!head.form_rate || (head.frame_time <= head.old_time))
        begin
            span_next = '0;
        end
        else if (span_full[TS_W-1:SPAN_W] != '0)
        begin
            span_next = '1;
        end
        else
        begin
            span_next = span_full[SPAN_W-1:0];
        end
    end

    // both sides of the rate compare
    assign lhs_next  = LHS_W'(cfg.noise_window) * LHS_W'(ebtng_pkg::US_PER_S);
    assign prod_next = PROD_W'(cfg.noise_rate_per_s) * PROD_W'(b1_span_reg);

    // final compare; zero span counts as zero rate
    assign rate_ok_next = b2_zero_reg ? (cfg.noise_rate_per_s == '0)
                                      : (PROD_W'(b2_lhs_reg) >= b2_prod_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (b1_en)
            begin
                b1_valid_reg <= pop;
            end
            if (b2_en)
            begin
                b2_valid_reg <= b1_valid_reg;
            end
            if (out_en)
            begin
                out_valid_reg <= b2_valid_reg;
            end
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            b1_fire_reg <= head.fire;
            b1_time_reg <= head.frame_time;
            b1_span_reg <= span_next;
        end
        if (b2_en && b1_valid_reg)
        begin
            b2_fire_reg <= b1_fire_reg;
            b2_time_reg <= b1_time_reg;
            b2_zero_reg <= (b1_span_reg == '0);
            b2_lhs_reg  <= lhs_next;
            b2_prod_reg <= prod_next;
        end
        if (out_en && b2_valid_reg)
        begin
            out_fire_reg    <= b2_fire_reg;
            out_rate_ok_reg <= rate_ok_next;
            out_time_reg    <= b2_time_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign batch_ready   = out_fire_reg;
    assign rate_ok       = out_rate_ok_reg;
    assign frame_time_us = out_time_reg;

endmodule

>>> tb/event_batch_trigger_noise_gate_tb.sv
// ----------------------------------------------------------------------------
// event_batch_trigger_noise_gate_tb
// Self-checking bench for the event batch trigger. It streams timestamp
// requests through the block and checks every batch-end result against a
// behavioral copy of the trigger and rate gate. Both trigger modes, the full
// range of window and rate settings, span saturation, backward steps, deep
// windows and output back-pressure are covered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module event_batch_trigger_noise_gate_tb;

    localparam int TS_W       = ebtng_pkg::TS_W;
    localparam int CNT_W      = ebtng_pkg::CNT_W;
    localparam int PERIOD_W   = ebtng_pkg::PERIOD_W;
    localparam int WIN_W      = ebtng_pkg::WIN_W;
    localparam int RATE_W     = ebtng_pkg::RATE_W;
    localparam int CFG_IDX_W  = ebtng_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = ebtng_pkg::CFG_DATA_W;

    localparam int RING        = ebtng_pkg::RING_DEPTH_DEF;
    localparam int SETTLE_CYC  = 8;
    localparam int HOLD_CYC    = 400;
    localparam int DRAIN_LIMIT = 20000;
    localparam int REPORT_MAX  = 10;
    localparam logic [TS_W-1:0] TS_MAX   = '1;
    localparam logic [63:0]     US_SCALE = 64'(ebtng_pkg::US_PER_S);
    localparam logic [63:0]     SPAN_MAX = 64'hFFFF_FFFF;

    typedef struct packed {
        logic            fired;
        logic            passed;
        logic [TS_W-1:0] stamp;
    } batch_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [TS_W-1:0]       timestamp_us;
    logic                  last_in_batch;
    logic                  out_valid;
    logic                  out_ready;
    logic                  batch_ready;
    logic                  rate_ok;
    logic [TS_W-1:0]       frame_time_us;

    // shadow of the block state and its registers
    logic [TS_W-1:0]  stamp_ring [RING];
    int unsigned      ring_wr;
    int unsigned      ring_fill;
    logic [CNT_W-1:0] events_pending;
    logic [TS_W-1:0]  trigger_time;
    logic [TS_W-1:0]  newest_stamp;
    ebtng_pkg::cfg_t  gate_cfg;
    batch_result_t    pending_results [$];
    batch_result_t    oldest_result;

    // stimulus control and bookkeeping
    int unsigned     tx_idle_pct = 21;
    int unsigned     rx_idle_pct = 88;
    int unsigned     hold_req    = 0;
    logic [TS_W-1:0] stamp_now;
    int unsigned     events_sent  = 0;
    int unsigned     results_seen = 0;
    int unsigned     fires_seen   = 0;
    int unsigned     passes_seen  = 0;
    int unsigned     mismatches   = 0;

    event_batch_trigger_noise_gate i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .timestamp_us  (timestamp_us),
        .last_in_batch (last_in_batch),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .batch_ready   (batch_ready),
        .rate_ok       (rate_ok),
        .frame_time_us (frame_time_us)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit
    initial
    begin
        #1_000_000;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("CHECK FAILED");
        $finish;
    end

    function automatic void note_mismatch(input string what, input logic [TS_W-1:0] want,
                                          input logic [TS_W-1:0] got);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
    endfunction

    // register write request, shadow registers follow at acceptance
    task automatic cfg_write(input ebtng_pkg::cfg_reg_t idx, input logic [CFG_DATA_W-1:0] d);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            ebtng_pkg::CFG_MODE:       gate_cfg.mode = ebtng_pkg::acc_mode_t'(d[0]);
            ebtng_pkg::CFG_PERIOD:     gate_cfg.period_us        = d[PERIOD_W-1:0];
            ebtng_pkg::CFG_MIN_EVENTS: gate_cfg.min_new_events   = d[CNT_W-1:0];
            ebtng_pkg::CFG_WINDOW:     gate_cfg.noise_window     = d[WIN_W-1:0];
            ebtng_pkg::CFG_RATE:       gate_cfg.noise_rate_per_s = d[RATE_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // one event request; on acceptance the shadow state advances and a batch end
    // queues its expected result
    task automatic send_event(input logic [TS_W-1:0] ts, input logic last);
        logic            fire;
        logic            pass;
        logic [TS_W:0]   due;
        logic [TS_W-1:0] oldest;
        logic [63:0]     span;
        int unsigned     n;
        batch_result_t   expected;
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        timestamp_us  <= ts;
        last_in_batch <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        events_sent++;

        // ring write and counters
        stamp_ring[ring_wr] = ts;
        ring_wr = (ring_wr + 1) % RING;
        if (ring_fill < RING)
            ring_fill++;
        newest_stamp = ts;
        if (events_pending != '1)
            events_pending++;
        if (!last)
            return;

        // trigger decision, the period sum cannot wrap
        due = {1'b0, trigger_time} + (TS_W+1)'(gate_cfg.period_us);
        if (gate_cfg.mode == ebtng_pkg::MODE_TIME)
            fire = ({1'b0, newest_stamp} >= due);
        else
            fire = (events_pending > gate_cfg.min_new_events);
        if (fire)
        begin
            events_pending = '0;
            trigger_time   = newest_stamp;
        end

        // rate gate over the newest window, span clipped to 32 bits
        n = (gate_cfg.noise_window < ring_fill) ? gate_cfg.noise_window : ring_fill;
        span = '0;
        if (n > 0 && ring_fill > n)
        begin
            oldest = stamp_ring[(ring_wr + RING - n) % RING];
            if (newest_stamp > oldest)
                span = 64'(newest_stamp - oldest);
            if (span > SPAN_MAX)
                span = SPAN_MAX;
        end
        if (span == 0)
            pass = (gate_cfg.noise_rate_per_s == '0);
        else
            pass = (64'(n) * US_SCALE >= 64'(gate_cfg.noise_rate_per_s) * span);

        expected = '{fired: fire, passed: pass, stamp: newest_stamp};
        pending_results.insert(pending_results.size(), expected);
    endtask

    // stop offering requests and wait until the block has gone quiet
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // random batches: mostly small steps, some repeats, a few steps back and
    // big jumps; wild adds fully random stamps
    task automatic send_batches(input int unsigned budget, input int unsigned max_len,
                                input bit wild);
        int unsigned sent;
        int unsigned len;
        int unsigned roll;
        sent = 0;
        while (sent < budget)
        begin
            len = ($urandom_range(19) == 0) ? $urandom_range(1, 4 * max_len)
                                            : $urandom_range(1, max_len);
            for (int unsigned i = 0; i < len; i++)
            begin
                roll = $urandom_range(999);
                if (wild && roll < 5)
                    stamp_now = {16'($urandom), $urandom};
                else if (roll < 15)
                    stamp_now += {14'h0, 2'($urandom), $urandom};
                else if (roll < 45 && stamp_now > 48'd50)
                    stamp_now -= 48'($urandom_range(1, 50));
                else if (roll >= 200)
                    stamp_now += 48'($urandom_range(1, 40));
                send_event(stamp_now, i == len - 1);
            end
            sent += len;
        end
    endtask

    // field extremes and the corner cases of trigger and rate gate
    task automatic test_directed();
        // very first event, nothing to form a rate from
        send_event(48'd0, 1'b1);

        // zero window gives a zero rate
        settle();
        cfg_write(ebtng_pkg::CFG_WINDOW, '0);
        cfg_write(ebtng_pkg::CFG_RATE, 32'd1);
        send_event(48'd10, 1'b1);

        // equal stamps, saturated span, then a step back
        settle();
        cfg_write(ebtng_pkg::CFG_WINDOW, 32'd2);
        send_event(48'd10, 1'b0);
        send_event(48'd10, 1'b1);
        send_event(TS_MAX, 1'b1);
        send_event(48'd7, 1'b1);

        // widest window code and top rate, upper data bits dropped
        settle();
        cfg_write(ebtng_pkg::CFG_WINDOW, '1);
        cfg_write(ebtng_pkg::CFG_RATE, '1);
        send_event(48'd8, 1'b1);

        // time mode with the longest period, then a zero period
        settle();
        cfg_write(ebtng_pkg::CFG_MODE, 32'hFFFF_FFFE);
        cfg_write(ebtng_pkg::CFG_PERIOD, '1);
        cfg_write(ebtng_pkg::CFG_WINDOW, 32'd1);
        send_event(TS_MAX, 1'b1);
        send_event(TS_MAX, 1'b1);
        settle();
        cfg_write(ebtng_pkg::CFG_PERIOD, '0);
        send_event(TS_MAX, 1'b1);

        // count mode never firing, then always firing
        settle();
        cfg_write(ebtng_pkg::CFG_MODE, 32'(ebtng_pkg::MODE_COUNT));
        cfg_write(ebtng_pkg::CFG_MIN_EVENTS, '1);
        send_event(48'd20, 1'b0);
        send_event(48'd21, 1'b1);
        settle();
        cfg_write(ebtng_pkg::CFG_MIN_EVENTS, '0);
        cfg_write(ebtng_pkg::CFG_RATE, '0);
        send_event(48'd3, 1'b1);
        stamp_now = 48'd3;
    endtask

    // count mode over a few thresholds
    task automatic test_count_trigger();
        logic [CNT_W-1:0] thresholds [3] = '{1, 4, 9};
        settle();
        cfg_write(ebtng_pkg::CFG_MODE, 32'(ebtng_pkg::MODE_COUNT));
        foreach (thresholds[t])
        begin
            settle();
            cfg_write(ebtng_pkg::CFG_MIN_EVENTS, thresholds[t]);
            cfg_write(ebtng_pkg::CFG_WINDOW, $urandom_range(1, 32));
            cfg_write(ebtng_pkg::CFG_RATE, $urandom_range(20000, 100000));
            send_batches(100, 10, 1'b0);
        end
    endtask

    // time mode over a few periods
    task automatic test_time_trigger();
        logic [PERIOD_W-1:0] periods [4] = '{0, 60, 250, 1000};
        settle();
        cfg_write(ebtng_pkg::CFG_MODE, 32'(ebtng_pkg::MODE_TIME));
        foreach (periods[p])
        begin
            settle();
            cfg_write(ebtng_pkg::CFG_PERIOD, periods[p]);
            cfg_write(ebtng_pkg::CFG_WINDOW, $urandom_range(1, 64));
            send_batches(80, 10, 1'b0);
        end
    endtask

    // rate gate across window sizes and thresholds, with wild stamps
    task automatic test_rate_gate();
        logic [WIN_W-1:0] windows [4] = '{1, 7, 64, 300};
        int unsigned      pick;
        settle();
        cfg_write(ebtng_pkg::CFG_MODE, 32'(ebtng_pkg::MODE_COUNT));
        cfg_write(ebtng_pkg::CFG_MIN_EVENTS, $urandom_range(0, 6));
        foreach (windows[w])
        begin
            settle();
            pick = $urandom_range(3);
            cfg_write(ebtng_pkg::CFG_WINDOW, 32'(windows[w]));
            if (pick == 0)
                cfg_write(ebtng_pkg::CFG_RATE, 32'd1);
            else if (pick == 1)
                cfg_write(ebtng_pkg::CFG_RATE, '1);
            else
                cfg_write(ebtng_pkg::CFG_RATE, $urandom_range(20000, 100000));
            send_batches(80, 10, 1'b1);
        end
    endtask

    // long receiver stall while batch ends keep coming, so the input backs up
    task automatic test_output_stall();
        settle();
        cfg_write(ebtng_pkg::CFG_MODE, 32'(ebtng_pkg::MODE_COUNT));
        cfg_write(ebtng_pkg::CFG_MIN_EVENTS, 32'd2);
        cfg_write(ebtng_pkg::CFG_WINDOW, 32'd8);
        cfg_write(ebtng_pkg::CFG_RATE, 32'd60000);
        hold_req = HOLD_CYC;
        send_batches(60, 1, 1'b0);
        send_batches(80, 8, 1'b0);
    endtask

    // sender stops mid-stream until all results are back
    task automatic test_input_pause();
        send_batches(80, 8, 1'b0);
        settle();
        send_batches(80, 8, 1'b0);
    endtask

    // windows reaching far back into the ring
    task automatic test_deep_window();
        // one forced trigger pulls the trigger time back near the stream
        settle();
        cfg_write(ebtng_pkg::CFG_MODE, 32'(ebtng_pkg::MODE_COUNT));
        cfg_write(ebtng_pkg::CFG_MIN_EVENTS, '0);
        stamp_now = 48'($urandom_range(1000));
        send_event(stamp_now, 1'b1);

        settle();
        cfg_write(ebtng_pkg::CFG_MODE, 32'(ebtng_pkg::MODE_TIME));
        cfg_write(ebtng_pkg::CFG_PERIOD, 32'd3000);
        cfg_write(ebtng_pkg::CFG_WINDOW, 32'd1000);
        cfg_write(ebtng_pkg::CFG_RATE, 32'd50000);
        send_batches(500, 40, 1'b0);

        // deepest window that still forms a rate, then one as deep as the ring
        settle();
        cfg_write(ebtng_pkg::CFG_WINDOW, 32'(ring_fill - 1));
        send_batches(100, 20, 1'b0);
        settle();
        cfg_write(ebtng_pkg::CFG_WINDOW, 32'(RING));
        send_batches(50, 20, 1'b0);
    endtask

    // receiver: random stalls, or a long hold-off counted here
    initial
    begin
        int unsigned hold_left;
        hold_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req != 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left != 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // result check against the oldest expected result
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (batch_ready === 1'b1)
                fires_seen++;
            if (rate_ok === 1'b1)
                passes_seen++;
            if (pending_results.size() == 0)
                note_mismatch("unexpected result", '0, frame_time_us);
            else
            begin
                oldest_result = pending_results.pop_front();
                if (batch_ready !== oldest_result.fired)
                    note_mismatch("batch_ready", oldest_result.fired, batch_ready);
                if (rate_ok !== oldest_result.passed)
                    note_mismatch("rate_ok", oldest_result.passed, rate_ok);
                if (frame_time_us !== oldest_result.stamp)
                    note_mismatch("frame_time_us", oldest_result.stamp, frame_time_us);
            end
        end
    end

    // test sequence
    initial
    begin
        int unsigned k;
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = ebtng_pkg::CFG_MODE;
        cfg_data      = '0;
        in_valid      = 1'b0;
        timestamp_us  = '0;
        last_in_batch = 1'b0;
        ring_wr        = 0;
        ring_fill      = 0;
        events_pending = '0;
        trigger_time   = '0;
        newest_stamp   = '0;
        stamp_now      = '0;
        gate_cfg = '{mode: ebtng_pkg::MODE_COUNT,
                     period_us: ebtng_pkg::PERIOD_RST,
                     min_new_events: ebtng_pkg::MIN_EVENTS_RST,
                     noise_window: ebtng_pkg::WINDOW_RST,
                     noise_rate_per_s: ebtng_pkg::RATE_RST};

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // sender mostly busy, receiver mostly stalling
        tx_idle_pct = 21;
        rx_idle_pct = 88;
        test_directed();
        test_count_trigger();
        test_time_trigger();

        // sender mostly idle, receiver mostly ready
        tx_idle_pct = 88;
        rx_idle_pct = 21;
        test_rate_gate();
        test_output_stall();

        // back to back
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_input_pause();
        test_deep_window();

        // drain the last results
        @(negedge clk);
        in_valid <= 1'b0;
        k = 0;
        while (pending_results.size() != 0 && k < DRAIN_LIMIT)
        begin
            @(posedge clk);
            k++;
        end
        repeat (SETTLE_CYC) @(posedge clk);
        if (pending_results.size() != 0)
            $display("%0d expected results never arrived", pending_results.size());

        $display("sent %0d events, checked %0d batch results (%0d triggers, %0d rate passes)",
                 events_sent, results_seen, fires_seen, passes_seen);
        $display("both trigger modes, windows from zero past the ring depth, span clipping, %s",
                 "steps back, deep windows and output back-pressure");
        if (mismatches == 0 && pending_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/ebtng_pkg.sv
hw/rtl/ebtng_ram.sv
hw/rtl/ebtng_queue.sv
hw/rtl/ebtng_front.sv
hw/rtl/ebtng_back.sv
hw/rtl/event_batch_trigger_noise_gate.sv
tb/event_batch_trigger_noise_gate_tb.sv
